### hdl/fkrs_pkg.sv
// Shared types and constants for the fence key range search block.
// Holds the transaction structs and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fkrs_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KEY_BYTES_DEF   = 8;
  localparam int KEY_W           = 64;
  localparam int SEG_W           = 10;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
  } fkrs_in_t;

  typedef struct packed {
    logic             in_range;
    logic [SEG_W-1:0] segment;
  } fkrs_out_t;

  typedef enum logic [1:0] {
    RD_LO  = 2'd0,
    RD_HI  = 2'd1,
    RD_MID = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    EM_MISS = 2'd0,
    EM_LO   = 2'd1,
    EM_MID  = 2'd2
  } emit_sel_t;

  typedef struct packed {
    logic      clr;
    logic      app;
    logic      cap;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      step;
    logic      emit;
    emit_sel_t emit_sel;
  } fkrs_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic len_one;
    logic key_lt;
    logic key_eq;
    logic key_gt;
    logic span_gt1;
  } fkrs_sts_t;

endpackage

`default_nettype wire

### hdl/fence_key_range_search.sv
// Fence key range search: floor binary search over a sorted boundary key table.
// Clear and append leave busy low and can be taken back to back. A query answers an empty or
// single-entry table from the entry count, else compares the key with the low and high bounds
// and halves the interval, each halving step reading the middle entry through the registered read.
// Busy holds the next transaction until the result edge; the receiver cannot stall the strobe.
// Synchronous reset empties the table (entry count zero), drops a search; stored keys are kept.
`timescale 1ns / 1ps
`default_nettype none

module fence_key_range_search #(
  parameter int TABLE_DEPTH = fkrs_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BYTES   = fkrs_pkg::KEY_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire fkrs_pkg::fkrs_in_t in_data,
  output logic                    out_valid,
  output fkrs_pkg::fkrs_out_t     out_data
);
  import fkrs_pkg::*;

  fkrs_cmd_t cmd;
  fkrs_sts_t sts;

  fkrs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_data.action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  fkrs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.action == ACT_QUERY) |=> busy)
    else $error("query transaction did not start a search");

  a_table_op_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.action != ACT_QUERY) |=> (!busy && !out_valid))
    else $error("table transaction stalled or produced a result");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.in_range) |-> (out_data.segment == '0))
    else $error("miss result carries a non-zero segment");

endmodule

`default_nettype wire

### hdl/fkrs_datapath.sv
// Datapath of the fence key range search: boundary table memory, entry count,
// search bounds, key compare and the result register. Depends on fkrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fkrs_datapath #(
  parameter int TABLE_DEPTH = fkrs_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BYTES   = fkrs_pkg::KEY_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fkrs_pkg::fkrs_in_t  in_data,
  input  wire fkrs_pkg::fkrs_cmd_t cmd,
  output fkrs_pkg::fkrs_sts_t      sts,
  output logic                     out_valid,
  output fkrs_pkg::fkrs_out_t      out_data
);
  import fkrs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = 8 * KEY_BYTES;

  logic [KW-1:0] mem [TABLE_DEPTH];
  logic [KW-1:0] rd_data_r;
  logic [KW-1:0] key_r, key_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [AW-1:0] mid_c, rd_addr;
  logic [AW:0]   mid_sum, span;
  logic          out_valid_r, out_valid_nxt;
  fkrs_out_t     out_r, out_nxt;
  logic          can_app;

  assign can_app = count_r < CW'(TABLE_DEPTH);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c   = mid_sum[AW:1];
  assign span    = {1'b0, hi_r} - {1'b0, lo_r};

  always_comb begin
    case (cmd.rd_sel)
      RD_LO:   rd_addr = lo_r;
      RD_HI:   rd_addr = hi_r;
      RD_MID:  rd_addr = mid_c;
      default: rd_addr = lo_r;
    endcase
  end

  // Table write on append, registered read for the search
  always_ff @(posedge clk) begin
    if (cmd.app && can_app) begin
      mem[count_r[AW-1:0]] <= in_data.key[KW-1:0];
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    count_nxt     = count_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    out_valid_nxt = cmd.emit;
    out_nxt       = out_r;
    if (cmd.clr) begin
      count_nxt = '0;
    end else if (cmd.app && can_app) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.cap) begin
      key_nxt = in_data.key[KW-1:0];
      lo_nxt  = '0;
      hi_nxt  = AW'(count_r - CW'(1));
    end
    if (cmd.rd_en && cmd.rd_sel == RD_MID) begin
      mid_nxt = mid_c;
    end
    // narrow the interval towards the key
    if (cmd.step) begin
      if (sts.key_lt) begin
        hi_nxt = mid_r;
      end else begin
        lo_nxt = mid_r;
      end
    end
    if (cmd.emit) begin
      case (cmd.emit_sel)
        EM_LO: begin
          out_nxt.in_range = 1'b1;
          out_nxt.segment  = SEG_W'(lo_r);
        end
        EM_MID: begin
          out_nxt.in_range = 1'b1;
          out_nxt.segment  = SEG_W'(mid_r);
        end
        default: begin
          out_nxt.in_range = 1'b0;
          out_nxt.segment  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    out_r <= out_nxt;
  end

  assign sts.len_zero = count_r == '0;
  assign sts.len_one  = count_r == CW'(1);
  assign sts.key_lt   = key_r < rd_data_r;
  assign sts.key_eq   = key_r == rd_data_r;
  assign sts.key_gt   = key_r > rd_data_r;
  assign sts.span_gt1 = span > (AW + 1)'(1);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### hdl/fkrs_ctrl.sv
// Controller of the fence key range search: accepts transactions and sequences
// the bound checks and halving steps of a query. Depends on fkrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fkrs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [1:0]          action,
  input  wire fkrs_pkg::fkrs_sts_t sts,
  output fkrs_pkg::fkrs_cmd_t      cmd,
  output logic                     busy
);
  import fkrs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_EVAL    = 6'b000010,
    ST_CMP_LO  = 6'b000100,
    ST_CMP_HI  = 6'b001000,
    ST_CMP_MID = 6'b010000,
    ST_NEXT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = state_r != ST_IDLE;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.rd_sel   = RD_LO;
    cmd.emit_sel = EM_MISS;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (action)
            ACT_CLEAR:  cmd.clr = 1'b1;
            ACT_APPEND: cmd.app = 1'b1;
            ACT_QUERY: begin
              cmd.cap   = 1'b1;
              state_nxt = ST_EVAL;
            end
            default: ;
          endcase
        end
      end
      ST_EVAL: begin
        if (sts.len_zero) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.len_one) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_LO;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_CMP_LO;
        end
      end
      ST_CMP_LO: begin
        if (sts.key_lt) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HI;
          state_nxt  = ST_CMP_HI;
        end
      end
      ST_CMP_HI, ST_NEXT: begin
        if (state_r == ST_CMP_HI && sts.key_gt) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.span_gt1) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID;
          state_nxt  = ST_CMP_MID;
        end else begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_LO;
          state_nxt    = ST_IDLE;
        end
      end
      ST_CMP_MID: begin
        if (sts.key_eq) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_MID;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_NEXT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for fence_key_range_search: directed table, large sorted fill,
// random load/query sequences. Depends on fkrs_pkg and the fence_key_range_search RTL only.
`timescale 1ns / 1ps

module tb;
  import fkrs_pkg::*;

  localparam logic [1:0]       ACT_UNUSED   = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MASK     = {KEY_W{1'b1}} >> (64 - 8 * KEY_BYTES_DEF);
  localparam int               RANDOM_ITEMS = 300;
  localparam int               FILL_ENTRIES = 256;
  localparam int               STALL_LIMIT  = 2000;
  localparam int               DRAIN_CYCLES = 30;

  typedef struct {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
    bit               known;
    fkrs_out_t        want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  fkrs_in_t  in_data;
  logic      out_valid;
  fkrs_out_t out_data;

  // Shadow copy of the boundary table and the lookups still in flight
  logic [KEY_W-1:0] fences [TABLE_DEPTH_DEF];
  int               fence_count;
  fkrs_out_t        pending_segments [$];
  stim_row_t        directed_rows [$];

  int idle_pct;
  int mismatch_count;
  int results_checked;
  int items_accepted;
  int peak_fill;

  fence_key_range_search dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Floor binary search over the shadow table, narrowing exactly as the block does
  function automatic fkrs_out_t predict_floor_segment(input logic [KEY_W-1:0] probe);
    fkrs_out_t res;
    int        lo;
    int        hi;
    int        mid;
    res = '0;
    if (fence_count == 0) return res;
    res.in_range = 1'b1;
    if (fence_count == 1) return res;
    lo = 0;
    hi = fence_count - 1;
    if (probe < fences[lo] || probe > fences[hi]) begin
      res.in_range = 1'b0;
      return res;
    end
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (probe < fences[mid]) begin
        hi = mid;
      end else if (probe == fences[mid]) begin
        res.segment = mid[SEG_W-1:0];
        return res;
      end else begin
        lo = mid;
      end
    end
    res.segment = lo[SEG_W-1:0];
    return res;
  endfunction

  // Probe keys aimed at exact hits, neighbours and both out-of-range sides
  function automatic logic [KEY_W-1:0] pick_probe();
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] last;
    int               idx;
    k = rand_key();
    if (fence_count == 0) return k;
    idx  = $urandom_range(fence_count - 1, 0);
    last = fences[fence_count-1];
    case ($urandom_range(5, 0))
      0, 1: k = fences[idx];
      2: k = fences[idx] + (($urandom_range(1, 0) == 1) ? 64'd1 : -64'd1);
      3: if (fences[0] != '0) k = k % fences[0];
      4: if (last != '1) k = last + 64'd1 + (k % ~last);
      default: ;
    endcase
    return k;
  endfunction

  function automatic void add_row(input logic [1:0] act, input logic [KEY_W-1:0] k,
                                  input bit known, input logic hit, input logic [SEG_W-1:0] seg);
    stim_row_t row;
    row.action        = act;
    row.key           = k;
    row.known         = known;
    row.want.in_range = hit;
    row.want.segment  = seg;
    directed_rows = {directed_rows, row};
  endfunction

  // Drive one transaction; returns at the edge that accepts it, shadow state updated
  task automatic send(input logic [1:0] act, input logic [KEY_W-1:0] k, input bit known,
                      input fkrs_out_t want);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_data.action <= act;
    in_data.key    <= k;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    items_accepted++;
    case (act)
      ACT_CLEAR: fence_count = 0;
      ACT_APPEND: begin
        if (fence_count < TABLE_DEPTH_DEF) begin
          fences[fence_count] = k & KEY_MASK;
          fence_count++;
          if (fence_count > peak_fill) peak_fill = fence_count;
        end
      end
      ACT_QUERY: begin
        if (known) pending_segments = {pending_segments, want};
        else pending_segments = {pending_segments, predict_floor_segment(k & KEY_MASK)};
      end
      default: ;
    endcase
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_segments.size() != 0);
  endtask

  // Results are sampled mid-cycle, well clear of the edges that move them
  always @(negedge clk) begin
    fkrs_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_segments.size() == 0) begin
        $error("result with nothing pending: in_range %0d segment %0d",
               out_data.in_range, out_data.segment);
        mismatch_count++;
      end else begin
        want = pending_segments.pop_front();
        results_checked++;
        if (out_data.in_range !== want.in_range) begin
          $error("in_range: expected %0d, got %0d", want.in_range, out_data.in_range);
          mismatch_count++;
        end
        if (out_data.segment !== want.segment) begin
          $error("segment: expected %0d, got %0d", want.segment, out_data.segment);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with neither an accepted transaction nor a result
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int               i;
    int               n_app;
    int               n_q;
    int               pick;
    int               random_sent;
    logic [KEY_W-1:0] cur;
    logic [KEY_W-1:0] nxt;
    logic [KEY_W-1:0] k;
    fkrs_out_t        none;

    none            = '0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_data         = '0;
    fence_count     = 0;
    idle_pct        = 14;
    mismatch_count  = 0;
    results_checked = 0;
    items_accepted  = 0;
    peak_fill       = 0;
    random_sent     = 0;

    // Empty table, single entry, out of range on both sides, exact hits, unused code,
    // minimum and maximum keys, unsorted table
    add_row(ACT_QUERY,  64'h0, 1'b1, 1'b0, '0);
    add_row(ACT_QUERY,  '1,    1'b1, 1'b0, '0);
    add_row(ACT_APPEND, 64'd5, 1'b0, 1'b0, '0);
    add_row(ACT_QUERY,  64'h0, 1'b1, 1'b1, '0);
    add_row(ACT_QUERY,  '1,    1'b1, 1'b1, '0);
    add_row(ACT_UNUSED, '1,    1'b0, 1'b0, '0);
    add_row(ACT_APPEND, 64'd100, 1'b0, 1'b0, '0);
    add_row(ACT_APPEND, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, 1'b0, '0);
    add_row(ACT_QUERY,  64'd4, 1'b1, 1'b0, '0);
    add_row(ACT_QUERY,  '1,    1'b1, 1'b0, '0);
    add_row(ACT_QUERY,  64'd5, 1'b0, 1'b0, '0);
    add_row(ACT_QUERY,  64'd100, 1'b0, 1'b0, '0);
    add_row(ACT_QUERY,  64'hFFFF_FFFF_FFFF_FFF0, 1'b0, 1'b0, '0);
    add_row(ACT_QUERY,  64'h8000_0000_0000_0000, 1'b0, 1'b0, '0);
    add_row(ACT_CLEAR,  64'h0, 1'b0, 1'b0, '0);
    add_row(ACT_QUERY,  64'h0, 1'b1, 1'b0, '0);
    add_row(ACT_APPEND, 64'h0, 1'b0, 1'b0, '0);
    add_row(ACT_APPEND, '1,    1'b0, 1'b0, '0);
    add_row(ACT_QUERY,  64'h0, 1'b0, 1'b0, '0);
    add_row(ACT_QUERY,  '1,    1'b0, 1'b0, '0);
    add_row(ACT_QUERY,  64'h5555_5555_5555_5555, 1'b0, 1'b0, '0);
    add_row(ACT_CLEAR,  '1,    1'b0, 1'b0, '0);
    add_row(ACT_APPEND, 64'd9, 1'b0, 1'b0, '0);
    add_row(ACT_APPEND, 64'd3, 1'b0, 1'b0, '0);
    add_row(ACT_APPEND, 64'd7, 1'b0, 1'b0, '0);
    add_row(ACT_QUERY,  64'd5, 1'b0, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[j])
      send(directed_rows[j].action, directed_rows[j].key, directed_rows[j].known,
           directed_rows[j].want);
    hold_until_drained();

    // Fill a large sorted table back to back, then probe it
    idle_pct = 0;
    send(ACT_CLEAR, rand_key(), 1'b0, none);
    for (i = 0; i < FILL_ENTRIES; i++) begin
      k          = rand_key();
      k[63:54]   = i[9:0];
      send(ACT_APPEND, k, 1'b0, none);
    end
    for (i = 0; i < 40; i++) send(ACT_QUERY, pick_probe(), 1'b0, none);

    // Random load-then-query sequences with some noise mixed in
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) idle_pct = 14;
      else if (random_sent < 2 * RANDOM_ITEMS / 3) idle_pct = 78;
      else idle_pct = 0;

      if ($urandom_range(7, 0) != 0) begin
        send(ACT_CLEAR, rand_key(), 1'b0, none);
        random_sent++;
      end
      n_app = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 60) : $urandom_range(24, 0);
      cur   = rand_key() >> $urandom_range(63, 0);
      for (i = 0; i < n_app; i++) begin
        send(ACT_APPEND, cur, 1'b0, none);
        random_sent++;
        nxt = ($urandom_range(9, 0) == 0) ? cur : cur + (rand_key() >> $urandom_range(63, 8));
        if (nxt >= cur) cur = nxt;
      end
      n_q = $urandom_range(20, 4);
      for (i = 0; i < n_q; i++) begin
        pick = $urandom_range(99, 0);
        if (pick < 5) begin
          send(ACT_UNUSED, rand_key(), 1'b0, none);
        end else if (pick < 8) begin
          // out-of-order boundary: table no longer sorted
          send(ACT_APPEND, rand_key(), 1'b0, none);
          random_sent++;
        end else begin
          send(ACT_QUERY, pick_probe(), 1'b0, none);
          random_sent++;
        end
      end
      if ($urandom_range(4, 0) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Accepted %0d transactions and checked %0d lookups; table fill reached %0d,",
             items_accepted, results_checked, peak_fill);
    $display("covering empty, single-entry, out-of-range, exact, unsorted and large tables.");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
